[design/atl_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the animation timeline loop tracker.
package atl_pkg;

    localparam int TIME_W  = 40;
    localparam int LEN_W   = 25;
    localparam int CNT_W   = 17;
    localparam int LOOP_W  = 16;
    localparam int DMAG_W  = 24;
    localparam int PROD_W  = TIME_W + CNT_W;
    localparam int STEP_W  = 6;

    localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(CNT_W);
    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(TIME_W);

    localparam logic [2:0] KIND_SEEK   = 3'd0;
    localparam logic [2:0] KIND_START  = 3'd1;
    localparam logic [2:0] KIND_PAUSE  = 3'd2;
    localparam logic [2:0] KIND_RESUME = 3'd3;
    localparam logic [2:0] KIND_STOP   = 3'd4;

    localparam logic [1:0] RUN_STOPPED = 2'd0;
    localparam logic [1:0] RUN_PAUSED  = 2'd1;
    localparam logic [1:0] RUN_RUNNING = 2'd2;

    localparam logic [1:0] CFG_LOOP_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_LOOP_TOTAL    = 2'd1;
    localparam logic [1:0] CFG_PLAY_BACKWARD = 2'd2;

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } mdu_op_t;

endpackage

[design/atl_mdu.sv]
`timescale 1ns / 1ps
// Iterative multiply / divide unit built around one shared adder.
module atl_mdu
    import atl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mdu_op_t             op,
    input  logic [TIME_W-1:0]   opa,
    input  logic [DMAG_W-1:0]   opb,
    output logic                done,
    output logic [PROD_W-1:0]   prod,
    output logic [TIME_W-1:0]   quot,
    output logic [DMAG_W-1:0]   rem
);

    logic [PROD_W-1:0] acc_reg;
    logic [TIME_W-1:0] sh_reg;
    logic [TIME_W-1:0] a_reg;
    logic [DMAG_W-1:0] b_reg;
    mdu_op_t           op_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [PROD_W-1:0] add_x;
    logic [PROD_W-1:0] add_y;
    logic              add_sub;
    logic [PROD_W:0]   add_sum;
    logic              ge;

    always_comb
    begin
        if (op_reg == MDU_MUL)
        begin
            add_x   = {acc_reg[PROD_W-2:0], 1'b0};
            add_y   = sh_reg[TIME_W-1] ? PROD_W'(a_reg) : '0;
            add_sub = 1'b0;
        end
        else
        begin
            add_x   = PROD_W'({acc_reg[DMAG_W-1:0], sh_reg[TIME_W-1]});
            add_y   = PROD_W'(b_reg);
            add_sub = 1'b1;
        end
        add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (PROD_W+1)'(add_sub);
        ge      = add_sum[PROD_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            sh_reg   <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            op_reg   <= MDU_MUL;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && run_reg && (cnt_reg == STEP_W'(1));
            if (start)
            begin
                acc_reg <= '0;
                a_reg   <= opa;
                b_reg   <= opb;
                op_reg  <= op;
                run_reg <= 1'b1;
                if (op == MDU_MUL)
                begin
                    sh_reg  <= {opb[CNT_W-1:0], (TIME_W-CNT_W)'(0)};
                    cnt_reg <= MUL_STEPS;
                end
                else
                begin
                    sh_reg  <= opa;
                    cnt_reg <= DIV_STEPS;
                end
            end
            else if (run_reg)
            begin
                if (op_reg == MDU_MUL)
                begin
                    acc_reg <= add_sum[PROD_W-1:0];
                    sh_reg  <= {sh_reg[TIME_W-2:0], 1'b0};
                end
                else
                begin
                    acc_reg <= ge ? PROD_W'(add_sum[DMAG_W-1:0]) : PROD_W'(add_x[DMAG_W-1:0]);
                    sh_reg  <= {sh_reg[TIME_W-2:0], ge};
                end
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                    run_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
    assign quot = sh_reg;
    assign rem  = acc_reg[DMAG_W-1:0];

endmodule

[design/animation_timeline_loop_tracker_core.sv]
`timescale 1ns / 1ps
// Looping animation timeline: run state, elapsed time, loop index and in-loop time.
// Pause, resume, refused and unknown items skip the multiply / divide unit, and so does stop,
// but for the forward end check time * (loop + 1) after the total (17-step multiplies).
// Seek, start from stopped: 17-step multiply, 40-step divide on the shared adder (none when the
// length is not positive), end check if the seek ends the run. A stall holds the next item.
// Reset: stopped, all times and loop index zero, loop length 0, loop count 1, forward.
module animation_timeline_loop_tracker_core
    import atl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [2:0]          kind,
    input  logic [TIME_W-1:0]   seek_ms,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [1:0]          run_state,
    output logic [LOOP_W-1:0]   loop_index,
    output logic [TIME_W-1:0]   loop_time_ms,
    output logic [TIME_W-1:0]   elapsed_ms,
    output logic                loop_changed,
    output logic                ended,
    output logic                ignored,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [LEN_W-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOT,
        S_TOT_W,
        S_SEEK,
        S_DIV_W,
        S_FIX,
        S_END,
        S_END_W,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [CNT_W-1:0]    total_reg;
    logic                back_reg;
    logic [1:0]          run_reg;
    logic [TIME_W-1:0]   elapsed_reg;
    logic [LOOP_W-1:0]   loop_reg;
    logic [TIME_W-1:0]   ilt_reg;
    logic [2:0]          kind_reg;
    logic [TIME_W-1:0]   seek_reg;
    logic [TIME_W-1:0]   dn_reg;
    logic                lchg_reg;
    logic                endd_reg;
    logic                ign_reg;

    logic                res_valid_reg;
    logic [1:0]          res_run_reg;
    logic [LOOP_W-1:0]   res_loop_reg;
    logic [TIME_W-1:0]   res_ilt_reg;
    logic [TIME_W-1:0]   res_elapsed_reg;
    logic                res_lchg_reg;
    logic                res_endd_reg;
    logic                res_ign_reg;

    logic                d_undef;
    logic                d_zero;
    logic                d_pos;
    logic [DMAG_W-1:0]   d_mag;
    logic                n_neg;
    logic                n_zero;
    logic [LOOP_W-1:0]   n_mag;
    logic                has_lim;
    logic [TIME_W-1:0]   m_arg;
    logic [TIME_W-1:0]   m_clamp;

    logic [TIME_W-1:0]   q_raw;
    logic [TIME_W-1:0]   fix_q;
    logic [TIME_W-1:0]   fix_t;
    logic [LOOP_W-1:0]   q_sat;
    logic                hit;
    logic                stop_hit;

    logic                cmd_ign;
    logic                cmd_endd;
    logic [1:0]          cmd_run;
    state_t              cmd_state;

    logic                mdu_start;
    mdu_op_t             mdu_op;
    logic [TIME_W-1:0]   mdu_a;
    logic [DMAG_W-1:0]   mdu_b;
    logic                mdu_done;
    logic [PROD_W-1:0]   mdu_prod;
    logic [TIME_W-1:0]   mdu_quot;
    logic [DMAG_W-1:0]   mdu_rem;

    assign d_undef = len_reg[LEN_W-1];
    assign d_zero  = (len_reg == '0);
    assign d_pos   = !d_undef && !d_zero;
    assign d_mag   = len_reg[DMAG_W-1:0];
    assign n_neg   = total_reg[CNT_W-1];
    assign n_zero  = (total_reg == '0);
    assign n_mag   = total_reg[LOOP_W-1:0];
    assign has_lim = !d_undef && !(d_pos && n_neg);

    always_comb
    begin
        if (kind_reg == KIND_SEEK)
            m_arg = seek_reg;
        else if (back_reg && d_pos)
            m_arg = n_neg ? TIME_W'(d_mag) : dn_reg;
        else
            m_arg = '0;
        m_clamp = (has_lim && (dn_reg < m_arg)) ? dn_reg : m_arg;
    end

    always_comb
    begin
        q_raw = d_pos ? mdu_quot : '0;
        hit   = !n_neg && (q_raw == TIME_W'(n_mag));
        fix_q = q_raw;
        if (hit)
        begin
            fix_t = d_pos ? TIME_W'(d_mag) : '0;
            fix_q = (n_mag != '0) ? TIME_W'(n_mag - LOOP_W'(1)) : '0;
        end
        else if (!back_reg)
            fix_t = d_pos ? TIME_W'(mdu_rem) : elapsed_reg;
        else if (!d_pos)
            fix_t = elapsed_reg;
        else if (elapsed_reg == '0)
            fix_t = '0;
        else if (mdu_rem == '0)
        begin
            fix_t = TIME_W'(d_mag);
            fix_q = q_raw - TIME_W'(1);
        end
        else
            fix_t = TIME_W'(mdu_rem);
        q_sat    = (fix_q > TIME_W'({LOOP_W{1'b1}})) ? {LOOP_W{1'b1}} : fix_q[LOOP_W-1:0];
        stop_hit = (!back_reg && has_lim && (elapsed_reg == dn_reg))
                || (back_reg && (elapsed_reg == '0));
    end

    // decode of an incoming command against the current run state
    always_comb
    begin
        cmd_ign   = 1'b0;
        cmd_endd  = 1'b0;
        cmd_run   = run_reg;
        cmd_state = S_DONE;
        case (kind)
            KIND_SEEK:
            begin
                cmd_state = S_TOT;
            end
            KIND_START:
            begin
                if (run_reg == RUN_RUNNING || n_zero)
                    cmd_ign = 1'b1;
                else
                begin
                    cmd_run = RUN_RUNNING;
                    if (run_reg == RUN_STOPPED)
                        cmd_state = S_TOT;
                end
            end
            KIND_PAUSE:
            begin
                if (run_reg != RUN_RUNNING || n_zero)
                    cmd_ign = 1'b1;
                else
                    cmd_run = RUN_PAUSED;
            end
            KIND_RESUME:
            begin
                if (run_reg != RUN_PAUSED || n_zero)
                    cmd_ign = 1'b1;
                else
                    cmd_run = RUN_RUNNING;
            end
            KIND_STOP:
            begin
                if (run_reg == RUN_STOPPED || n_zero)
                    cmd_ign = 1'b1;
                else if (d_undef || n_neg)
                begin
                    cmd_endd = 1'b1;
                    cmd_run  = RUN_STOPPED;
                end
                else if (back_reg)
                begin
                    cmd_endd = (ilt_reg == '0);
                    cmd_run  = RUN_STOPPED;
                end
                else
                    cmd_state = S_TOT;
            end
            default:
            begin
                cmd_ign = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        mdu_start = 1'b0;
        mdu_op    = MDU_MUL;
        mdu_a     = TIME_W'(d_mag);
        mdu_b     = DMAG_W'(n_mag);
        case (state_reg)
            S_TOT:
            begin
                mdu_start = 1'b1;
            end
            S_SEEK:
            begin
                mdu_start = d_pos;
                mdu_op    = MDU_DIV;
                mdu_a     = m_clamp;
                mdu_b     = d_mag;
            end
            S_END:
            begin
                mdu_start = 1'b1;
                mdu_a     = ilt_reg;
                mdu_b     = DMAG_W'({1'b0, loop_reg} + CNT_W'(1));
            end
            default:
            begin
                mdu_start = 1'b0;
            end
        endcase
    end

    atl_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mdu_start),
        .op    (mdu_op),
        .opa   (mdu_a),
        .opb   (mdu_b),
        .done  (mdu_done),
        .prod  (mdu_prod),
        .quot  (mdu_quot),
        .rem   (mdu_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            len_reg         <= '0;
            total_reg       <= CNT_W'(1);
            back_reg        <= 1'b0;
            run_reg         <= RUN_STOPPED;
            elapsed_reg     <= '0;
            loop_reg        <= '0;
            ilt_reg         <= '0;
            kind_reg        <= KIND_SEEK;
            seek_reg        <= '0;
            dn_reg          <= '0;
            lchg_reg        <= 1'b0;
            endd_reg        <= 1'b0;
            ign_reg         <= 1'b0;
            res_valid_reg   <= 1'b0;
            res_run_reg     <= RUN_STOPPED;
            res_loop_reg    <= '0;
            res_ilt_reg     <= '0;
            res_elapsed_reg <= '0;
            res_lchg_reg    <= 1'b0;
            res_endd_reg    <= 1'b0;
            res_ign_reg     <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && !result_stall && state_reg != S_DONE)
                res_valid_reg <= 1'b0;

            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_LOOP_LENGTH:   len_reg   <= cfg_data;
                    CFG_LOOP_TOTAL:    total_reg <= cfg_data[CNT_W-1:0];
                    CFG_PLAY_BACKWARD: back_reg  <= cfg_data[0];
                    default:           ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        kind_reg  <= kind;
                        seek_reg  <= seek_ms;
                        lchg_reg  <= 1'b0;
                        endd_reg  <= cmd_endd;
                        ign_reg   <= cmd_ign;
                        run_reg   <= cmd_run;
                        state_reg <= cmd_state;
                    end
                end
                S_TOT:
                begin
                    state_reg <= S_TOT_W;
                end
                S_TOT_W:
                begin
                    if (mdu_done)
                    begin
                        dn_reg    <= mdu_prod[TIME_W-1:0];
                        state_reg <= (kind_reg == KIND_STOP) ? S_END : S_SEEK;
                    end
                end
                S_SEEK:
                begin
                    elapsed_reg <= m_clamp;
                    state_reg   <= d_pos ? S_DIV_W : S_FIX;
                end
                S_DIV_W:
                begin
                    if (mdu_done)
                        state_reg <= S_FIX;
                end
                S_FIX:
                begin
                    ilt_reg   <= fix_t;
                    loop_reg  <= q_sat;
                    lchg_reg  <= (q_sat != loop_reg);
                    if (stop_hit && run_reg != RUN_STOPPED && !n_zero)
                    begin
                        if (d_undef || n_neg)
                        begin
                            endd_reg  <= 1'b1;
                            run_reg   <= RUN_STOPPED;
                            state_reg <= S_DONE;
                        end
                        else if (!back_reg)
                            state_reg <= S_END;
                        else
                        begin
                            endd_reg  <= (fix_t == '0);
                            run_reg   <= RUN_STOPPED;
                            state_reg <= S_DONE;
                        end
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_END:
                begin
                    state_reg <= S_END_W;
                end
                S_END_W:
                begin
                    if (mdu_done)
                    begin
                        endd_reg  <= (mdu_prod == PROD_W'(dn_reg));
                        run_reg   <= RUN_STOPPED;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!res_valid_reg || !result_stall)
                    begin
                        res_valid_reg   <= 1'b1;
                        res_run_reg     <= run_reg;
                        res_loop_reg    <= loop_reg;
                        res_ilt_reg     <= ilt_reg;
                        res_elapsed_reg <= elapsed_reg;
                        res_lchg_reg    <= lchg_reg;
                        res_endd_reg    <= endd_reg;
                        res_ign_reg     <= ign_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign run_state    = res_run_reg;
    assign loop_index   = res_loop_reg;
    assign loop_time_ms = res_ilt_reg;
    assign elapsed_ms   = res_elapsed_reg;
    assign loop_changed = res_lchg_reg;
    assign ended        = res_endd_reg;
    assign ignored      = res_ign_reg;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the looping animation timeline tracker core.
module testbench;
    import atl_pkg::*;

    localparam logic [2:0] KIND_RSVD_LO = 3'd5;
    localparam logic [2:0] KIND_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [1:0]        run_state;
        logic [LOOP_W-1:0] loop_index;
        logic [TIME_W-1:0] loop_time_ms;
        logic [TIME_W-1:0] elapsed_ms;
        logic              loop_changed;
        logic              ended;
        logic              ignored;
    } timeline_status_t;

    class timeline_scoreboard;
        logic [LEN_W-1:0]  len_reg;
        logic [CNT_W-1:0]  cnt_reg;
        logic              back_reg;
        logic [1:0]        mode;
        logic [TIME_W-1:0] elapsed;
        logic [LOOP_W-1:0] loop_no;
        logic [TIME_W-1:0] loop_time;
        bit                lchg;
        bit                endd;
        timeline_status_t  expected_status[$];
        int                errors;

        function new();
            len_reg   = '0;
            cnt_reg   = CNT_W'(1);
            back_reg  = 1'b0;
            mode      = RUN_STOPPED;
            elapsed   = '0;
            loop_no   = '0;
            loop_time = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [LEN_W-1:0] data);
            case (idx)
                CFG_LOOP_LENGTH:   len_reg = data;
                CFG_LOOP_TOTAL:    cnt_reg = data[CNT_W-1:0];
                CFG_PLAY_BACKWARD: back_reg = data[0];
                default: ;
            endcase
        endfunction

        // lengths and counts below -1 behave as -1
        function longint eff_len();
            longint v;
            v = $signed(len_reg);
            return (v < -1) ? -1 : v;
        endfunction

        function longint eff_cnt();
            longint v;
            v = $signed(cnt_reg);
            return (v < -1) ? -1 : v;
        endfunction

        function longint span_ms();
            longint d, n;
            d = eff_len();
            n = eff_cnt();
            if (d <= 0)
                return d;
            if (n < 0)
                return -1;
            return d * n;
        endfunction

        function bit stop_now();
            longint d, n;
            d = eff_len();
            n = eff_cnt();
            if (mode == RUN_STOPPED || n == 0)
                return 1'b0;
            if (d == -1 || n < 0)
                endd = 1'b1;
            else if (!back_reg)
            begin
                if (longint'(loop_time) * (longint'(loop_no) + 1) == d * n)
                    endd = 1'b1;
            end
            else if (loop_time == '0)
                endd = 1'b1;
            mode = RUN_STOPPED;
            return 1'b1;
        endfunction

        function void seek_to(logic [TIME_W-1:0] ms);
            longint d, n, total;
            longint unsigned m, q, t, ud;
            logic [LOOP_W-1:0] old;
            d     = eff_len();
            n     = eff_cnt();
            total = span_ms();
            m     = ms;
            old   = loop_no;
            if (d > 0)
                ud = d;
            else
                ud = 1;
            if (total != -1 && $unsigned(total) < m)
                m = total;
            elapsed = m[TIME_W-1:0];
            q = (d <= 0) ? 0 : m / ud;
            if (n >= 0 && q == $unsigned(n))
            begin
                t = (d > 0) ? ud : 0;
                q = (n > 0) ? n - 1 : 0;
            end
            else if (!back_reg)
                t = (d <= 0) ? m : m % ud;
            else if (d <= 0)
                t = m;
            else if (m == 0)
                t = 0;
            else
            begin
                // backward rounding: exact multiples sit at the end of the lower loop
                t = (m - 1) % ud + 1;
                if (t == ud)
                    q = q - 1;
            end
            if (q > 65535)
                q = 65535;
            loop_time = t[TIME_W-1:0];
            loop_no   = q[LOOP_W-1:0];
            if (loop_no != old)
                lchg = 1'b1;
            if ((!back_reg && total >= 0 && m == $unsigned(total)) || (back_reg && m == 0))
                void'(stop_now());
        endfunction

        function void note_command(logic [2:0] kind, logic [TIME_W-1:0] seek);
            timeline_status_t r;
            longint n, d;
            logic [TIME_W-1:0] arg;
            logic [1:0] was;
            bit ign;
            lchg = 1'b0;
            endd = 1'b0;
            ign  = 1'b0;
            n    = eff_cnt();
            case (kind)
                KIND_SEEK: seek_to(seek);
                KIND_START:
                begin
                    if (mode == RUN_RUNNING || n == 0)
                        ign = 1'b1;
                    else
                    begin
                        was  = mode;
                        mode = RUN_RUNNING;
                        if (was == RUN_STOPPED)
                        begin
                            d   = eff_len();
                            arg = '0;
                            if (back_reg && d > 0)
                                arg = TIME_W'((n < 0) ? d : d * n);
                            seek_to(arg);
                        end
                    end
                end
                KIND_PAUSE:
                begin
                    if (mode != RUN_RUNNING || n == 0)
                        ign = 1'b1;
                    else
                        mode = RUN_PAUSED;
                end
                KIND_RESUME:
                begin
                    if (mode != RUN_PAUSED || n == 0)
                        ign = 1'b1;
                    else
                        mode = RUN_RUNNING;
                end
                KIND_STOP:
                begin
                    if (!stop_now())
                        ign = 1'b1;
                end
                default: ign = 1'b1;
            endcase
            r.run_state    = mode;
            r.loop_index   = loop_no;
            r.loop_time_ms = loop_time;
            r.elapsed_ms   = elapsed;
            r.loop_changed = lchg;
            r.ended        = endd;
            r.ignored      = ign;
            expected_status.push_back(r);
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            if (errors < 50)
                $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(timeline_status_t got);
            timeline_status_t want;
            if (expected_status.size() == 0)
            begin
                report("result with no item outstanding", got.elapsed_ms, 0);
                return;
            end
            want = expected_status.pop_front();
            if (got.run_state != want.run_state)
                report("run_state", got.run_state, want.run_state);
            if (got.loop_index != want.loop_index)
                report("loop_index", got.loop_index, want.loop_index);
            if (got.loop_time_ms != want.loop_time_ms)
                report("loop_time_ms", got.loop_time_ms, want.loop_time_ms);
            if (got.elapsed_ms != want.elapsed_ms)
                report("elapsed_ms", got.elapsed_ms, want.elapsed_ms);
            if (got.loop_changed != want.loop_changed)
                report("loop_changed", got.loop_changed, want.loop_changed);
            if (got.ended != want.ended)
                report("ended", got.ended, want.ended);
            if (got.ignored != want.ignored)
                report("ignored", got.ignored, want.ignored);
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    logic [2:0]        kind = '0;
    logic [TIME_W-1:0] seek_ms = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [1:0]        run_state;
    logic [LOOP_W-1:0] loop_index;
    logic [TIME_W-1:0] loop_time_ms;
    logic [TIME_W-1:0] elapsed_ms;
    logic              loop_changed;
    logic              ended;
    logic              ignored;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [LEN_W-1:0]  cfg_data = '0;

    timeline_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len = 0;
    int items_sent = 0;

    animation_timeline_loop_tracker_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .seek_ms      (seek_ms),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .run_state    (run_state),
        .loop_index   (loop_index),
        .loop_time_ms (loop_time_ms),
        .elapsed_ms   (elapsed_ms),
        .loop_changed (loop_changed),
        .ended        (ended),
        .ignored      (ignored),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [TIME_W-1:0] rand40();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    // seek targets around the loop boundaries and the end of the timeline, plus random ones
    function automatic logic [TIME_W-1:0] pick_seek();
        longint d, total, k, v;
        d     = sb.eff_len();
        total = sb.span_ms();
        k     = $urandom_range(0, 8);
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = total;
            2: v = total - 1;
            3: v = total + 1;
            4: v = k * d;
            5: v = k * d + 1;
            6: v = k * d - 1;
            7: v = $urandom_range(0, 1000);
            8: v = rand40();
            default: v = -1;
        endcase
        return v[TIME_W-1:0];
    endfunction

    task send_item(logic [2:0] k, logic [TIME_W-1:0] s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= k;
        seek_ms    <= s;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_command(k, s);
        items_sent++;
    endtask

    task write_reg(logic [1:0] idx, logic [LEN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // drains outstanding items first so the block is idle during writes
    task write_config(logic [LEN_W-1:0] len, logic [CNT_W-1:0] cnt, logic back);
        logic [LEN_W-1:0] pad;
        pad = LEN_W'($urandom);
        item_valid <= 1'b0;
        while (sb.expected_status.size() != 0)
            @(posedge clk);
        write_reg(CFG_LOOP_LENGTH, len);
        write_reg(CFG_LOOP_TOTAL, {pad[LEN_W-1:CNT_W], cnt});
        write_reg(CFG_PLAY_BACKWARD, {pad[LEN_W-1:1], back});
        cfg_valid <= 1'b0;
    endtask

    task run_phase(int goal);
        int seeks;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                send_item(KIND_START, rand40());
                seeks = $urandom_range(1, 4);
                repeat (seeks)
                    send_item(KIND_SEEK, pick_seek());
                if ($urandom_range(0, 1) == 1)
                begin
                    send_item(KIND_PAUSE, rand40());
                    send_item(KIND_SEEK, pick_seek());
                    send_item(KIND_RESUME, rand40());
                end
                send_item(KIND_STOP, rand40());
            end
            else
                send_item(3'($urandom_range(0, 7)),
                          ($urandom_range(0, 1) == 1) ? pick_seek() : rand40());
        end
    endtask

    initial
    begin
        int hold_cnt;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                hold_cnt = hold_len;
                hold_len = 0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial
    begin
        timeline_status_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                got = {run_state, loop_index, loop_time_ms, elapsed_ms,
                       loop_changed, ended, ignored};
                sb.check_result(got);
            end
        end
    end

    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
        int ph;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // three loops of 100 ms, forward
        write_config(LEN_W'(100), CNT_W'(3), 1'b0);
        send_item(KIND_START, rand40());
        send_item(KIND_SEEK, TIME_W'(150));
        send_item(KIND_PAUSE, rand40());
        send_item(KIND_PAUSE, rand40());
        send_item(KIND_RESUME, rand40());
        send_item(KIND_RESUME, rand40());
        send_item(KIND_START, rand40());
        send_item(KIND_SEEK, TIME_W'(300));
        send_item(KIND_STOP, rand40());
        send_item(KIND_SEEK, '1);
        send_item(KIND_RSVD_LO, rand40());
        send_item(KIND_RSVD_HI, rand40());
        send_item(KIND_START, rand40());
        send_item(KIND_STOP, rand40());

        // backward: rewind to the end, then seek to a loop edge and to zero
        write_config(LEN_W'(100), CNT_W'(3), 1'b1);
        send_item(KIND_START, rand40());
        send_item(KIND_SEEK, TIME_W'(200));
        send_item(KIND_SEEK, '0);

        // length and count below -1
        write_config(25'h1000000, 17'h10000, 1'b1);
        send_item(KIND_START, rand40());
        send_item(KIND_SEEK, TIME_W'(12345));
        send_item(KIND_STOP, rand40());

        // zero loop count refuses state changes
        write_config(LEN_W'(50), '0, 1'b0);
        send_item(KIND_START, rand40());
        send_item(KIND_SEEK, TIME_W'(70));
        send_item(KIND_STOP, rand40());

        // endless with 1 ms loops: loop index saturates
        write_config(LEN_W'(1), '1, 1'b0);
        send_item(KIND_START, rand40());
        send_item(KIND_SEEK, '1);
        send_item(KIND_STOP, rand40());

        for (ph = 0; ph < 12; ph++)
        begin
            if (ph < 4)
            begin
                send_idle_pct = 8;
                recv_idle_pct = 45;
            end
            else if (ph < 8)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 8;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(0, 7))
                0: len = '1;
                1: len = '0;
                2: len = LEN_W'($urandom_range(1, 16));
                3: len = LEN_W'($urandom_range(1, 2000));
                4: len = 25'h0FFFFFF;
                5: len = 25'h1000000;
                6: len = LEN_W'($urandom);
                default: len = 25'h1FFFFFE;
            endcase
            case ($urandom_range(0, 7))
                0: cnt = '1;
                1: cnt = '0;
                2: cnt = CNT_W'(1);
                3: cnt = CNT_W'($urandom_range(2, 6));
                4: cnt = 17'h0FFFF;
                5: cnt = 17'h10000;
                6: cnt = CNT_W'($urandom);
                default: cnt = CNT_W'($urandom_range(1, 40));
            endcase
            if (ph == 0)
            begin
                len = 25'h0FFFFFF;
                cnt = 17'h0FFFF;
            end
            else if (ph == 1)
            begin
                len = LEN_W'(1);
                cnt = CNT_W'(1);
            end
            write_config(len, cnt, 1'($urandom_range(0, 1)));
            if (ph == 2)
                hold_len = 300;
            run_phase(items_sent + 33);
        end

        item_valid <= 1'b0;
        while (sb.expected_status.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.expected_status.size() != 0)
            sb.report("results never delivered", sb.expected_status.size(), 0);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
design/atl_pkg.sv
design/atl_mdu.sv
design/animation_timeline_loop_tracker_core.sv
dv/testbench.sv
